### rtl/core/bgd_pkg.sv
package bgd_pkg;

  // Fixed field widths of the channels and the config port
  localparam int unsigned NowW     = 32;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // Config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LOW   = 3'd0,
    CFG_DEBOUNCE     = 3'd1,
    CFG_HOLD_THRESH  = 3'd2,
    CFG_DBL_WINDOW   = 3'd3,
    CFG_HOLD_PERIOD  = 3'd4,
    CFG_HOLD_ENABLE  = 3'd5,
    CFG_HOLD_REPEAT  = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic                RstActiveLow  = 1'b1;
  localparam logic [CfgDataW-1:0] RstDebounce   = 16'd50;
  localparam logic [CfgDataW-1:0] RstHoldThresh = 16'd1000;
  localparam logic [CfgDataW-1:0] RstDblWindow  = 16'd300;
  localparam logic [CfgDataW-1:0] RstHoldPeriod = 16'd200;
  localparam logic                RstHoldEnable = 1'b0;
  localparam logic                RstHoldRepeat = 1'b0;

  // One result beat
  typedef struct packed {
    logic down_event;
    logic up_event;
    logic click_event;
    logic double_click_event;
    logic hold_event;
  } events_t;

endpackage

### rtl/core/bgd_if.sv
// Sample channel: raw pin level plus millisecond timestamp
interface bgd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        pin_level;
  logic [bgd_pkg::NowW-1:0]    now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// Event channel: one beat per sample
interface bgd_out_if;
  logic valid;
  logic ready;
  logic down_event;
  logic up_event;
  logic click_event;
  logic double_click_event;
  logic hold_event;

  modport source (output valid, output down_event, output up_event, output click_event,
                  output double_click_event, output hold_event, input ready);
  modport sink   (input valid, input down_event, input up_event, input click_event,
                  input double_click_event, input hold_event, output ready);
endinterface

### rtl/core/button_gesture_detector_top.sv
// Channel   | Dir | Payload                                          | Handshake
// ----------+-----+--------------------------------------------------+-----------
// in_i      | in  | pin_level, now_ms[31:0]                          | valid/ready
// out_o     | out | down, up, click, double_click, hold events       | valid/ready
// cfg_*_i   | in  | cfg_idx_i[2:0], cfg_wdata_i[15:0]                | cfg_we_i
//
// One sample beat per clock while out_o takes beats, one event beat per sample,
// result in the cycle after the sample: the decision logic (one TIME_BITS
// subtract/compare per path) sits between the input beat and the result register.
// in_i.ready is high whenever the result register is empty or being drained,
// so samples stream back to back while out_o keeps taking beats.
// A stall on out_o holds the result and blocks the next sample only then.
// rst_ni (async, low) loads config defaults and clears all timing state.
module button_gesture_detector_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bgd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bgd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  bgd_in_if.sink                           in_i,
  bgd_out_if.source                        out_o
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic                          active_low_q;
  logic [bgd_pkg::CfgDataW-1:0]  debounce_q;
  logic [bgd_pkg::CfgDataW-1:0]  hold_thresh_q;
  logic [bgd_pkg::CfgDataW-1:0]  dbl_window_q;
  logic [bgd_pkg::CfgDataW-1:0]  hold_period_q;
  logic                          hold_enable_q;
  logic                          hold_repeat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q  <= bgd_pkg::RstActiveLow;
      debounce_q    <= bgd_pkg::RstDebounce;
      hold_thresh_q <= bgd_pkg::RstHoldThresh;
      dbl_window_q  <= bgd_pkg::RstDblWindow;
      hold_period_q <= bgd_pkg::RstHoldPeriod;
      hold_enable_q <= bgd_pkg::RstHoldEnable;
      hold_repeat_q <= bgd_pkg::RstHoldRepeat;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bgd_pkg::CFG_ACTIVE_LOW:  active_low_q  <= cfg_wdata_i[0];
        bgd_pkg::CFG_DEBOUNCE:    debounce_q    <= cfg_wdata_i;
        bgd_pkg::CFG_HOLD_THRESH: hold_thresh_q <= cfg_wdata_i;
        bgd_pkg::CFG_DBL_WINDOW:  dbl_window_q  <= cfg_wdata_i;
        bgd_pkg::CFG_HOLD_PERIOD: hold_period_q <= cfg_wdata_i;
        bgd_pkg::CFG_HOLD_ENABLE: hold_enable_q <= cfg_wdata_i[0];
        bgd_pkg::CFG_HOLD_REPEAT: hold_repeat_q <= cfg_wdata_i[0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Button state
  // ---------------------------------------------------------------------------
  logic                 last_level_q, last_level_d;
  logic                 pressed_q, pressed_d;
  logic [TIME_BITS-1:0] last_change_q, last_change_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic [TIME_BITS-1:0] last_click_q, last_click_d;

  // Result register
  logic             out_valid_q;
  bgd_pkg::events_t res_q, res_d;

  logic                 fire;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_click;
  logic                 change_ok;
  logic                 new_pressed;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  // Timestamp folded to the internal time width; all differences wrap
  assign now_t        = TIME_BITS'(in_i.now_ms);
  assign since_change = now_t - last_change_q;
  assign since_click  = now_t - last_click_q;
  assign change_ok    = (in_i.pin_level != last_level_q) &&
                        (since_change > TIME_BITS'(debounce_q));
  assign new_pressed  = in_i.pin_level ^ active_low_q;

  always_comb begin
    last_level_d  = last_level_q;
    pressed_d     = pressed_q;
    last_change_d = last_change_q;
    deadline_d    = deadline_q;
    last_click_d  = last_click_q;
    res_d         = '0;

    if (change_ok) begin
      // Debounced edge
      pressed_d     = new_pressed;
      last_change_d = now_t;
      last_level_d  = in_i.pin_level;
      if (new_pressed) begin
        deadline_d       = now_t + TIME_BITS'(hold_thresh_q);
        res_d.down_event = 1'b1;
      end else begin
        res_d.up_event = 1'b1;
        if (since_click < TIME_BITS'(dbl_window_q)) begin
          res_d.double_click_event = 1'b1;
          last_click_d             = '0;   // next release starts a fresh pair
        end else if (since_change < TIME_BITS'(hold_thresh_q)) begin
          res_d.click_event = 1'b1;
          last_click_d      = now_t;
        end
      end
    end else if (hold_enable_q && pressed_q) begin
      // Deadline compare is plain unsigned, no wrap handling
      if (now_t > deadline_q) begin
        res_d.hold_event = 1'b1;
        if (hold_repeat_q) begin
          deadline_d = now_t + TIME_BITS'(hold_period_q);
        end else begin
          pressed_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q  <= 1'b1;
      pressed_q     <= 1'b0;
      last_change_q <= '0;
      deadline_q    <= '0;
      last_click_q  <= '0;
    end else if (fire) begin
      last_level_q  <= last_level_d;
      pressed_q     <= pressed_d;
      last_change_q <= last_change_d;
      deadline_q    <= deadline_d;
      last_click_q  <= last_click_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.down_event         = res_q.down_event;
  assign out_o.up_event           = res_q.up_event;
  assign out_o.click_event        = res_q.click_event;
  assign out_o.double_click_event = res_q.double_click_event;
  assign out_o.hold_event         = res_q.hold_event;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_evt_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({res_q.down_event, res_q.up_event, res_q.hold_event}))
    else $error("down/up/hold events overlap");

  a_click_needs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.click_event || res_q.double_click_event))
      |-> (res_q.up_event && !(res_q.click_event && res_q.double_click_event)))
    else $error("click without release or click and double click together");

  a_down_sets_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ((!res_q.down_event || pressed_q) && (!res_q.up_event || !pressed_q)))
    else $error("pressed state disagrees with edge event");

  a_beat_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted sample left no result beat");

endmodule
